@@ sv/four_fold_weighted_reflection_merge_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the four-fold weighted reflection merge unit
// Shared property wrappers; clock and reset are the block's own ports.
// ----------------------------------------------------------------------------
`ifndef FOUR_FOLD_WEIGHTED_REFLECTION_MERGE_UNIT_ASSERT_SVH
`define FOUR_FOLD_WEIGHTED_REFLECTION_MERGE_UNIT_ASSERT_SVH

// same-cycle implication
`define FFWRM_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ffwrm assertion failed");

// next-cycle implication
`define FFWRM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ffwrm assertion failed");

`endif

@@ sv/ffwrm_pkg.sv @@
// ----------------------------------------------------------------------------
// ffwrm_pkg
// Widths, constants and pipeline payload types of the orbit merge unit.
// ----------------------------------------------------------------------------
package ffwrm_pkg;

   localparam int AMP_W   = 24;
   localparam int SIG_W   = 16;
   localparam int ORBIT   = 4;
   localparam int WSH     = 40;              // weight = 2^WSH / (sigma^2 + 1)
   localparam int W_W     = WSH + 1;         // weight bits
   localparam int DEN_W   = 2 * SIG_W;       // sigma^2 + 1 fits
   localparam int SSUM_W  = SIG_W + 2;
   localparam int CNT_W   = 3;
   localparam int WSUM_W  = W_W + 2;
   localparam int P0_W    = 2 * AMP_W;
   localparam int P1_W    = AMP_W + W_W - AMP_W;  // mag * w[W_W-1:AMP_W]
   localparam int PROD_W  = AMP_W + W_W;
   localparam int ACC_W   = PROD_W + 2;      // signed sum of four
   localparam int MAG_W   = ACC_W - 1;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = 2;
   localparam int QCNT_W  = 3;
   localparam int RECIP3_SH = 20;
   localparam logic [RECIP3_SH-1:0] RECIP3 = RECIP3_SH'(((1 << RECIP3_SH) + 2) / 3);
   localparam int REQ_W   = ORBIT * (AMP_W + SIG_W);
   localparam int RSP_W   = AMP_W + SIG_W;

   typedef struct packed {
      logic [ORBIT-1:0]                neg;
      logic [ORBIT-1:0]                pres;
      logic [ORBIT-1:0][AMP_W-1:0]     mag;
      logic [ORBIT-1:0][DEN_W-1:0]     den;
      logic [CNT_W-1:0]                cnt;
      logic [SSUM_W-1:0]               ssum;
   } ffwrm_item_type;

   typedef struct packed {
      ffwrm_item_type                  item;
      logic [ORBIT-1:0][DEN_W-1:0]     rem;
      logic [ORBIT-1:0][W_W-1:0]       q;
   } ffwrm_wstage_type;

   typedef struct packed {
      logic [ORBIT-1:0]                neg;
      logic [CNT_W-1:0]                cnt;
      logic [SSUM_W-1:0]               ssum;
      logic [WSUM_W-1:0]               wsum;
      logic [ORBIT-1:0][P0_W-1:0]      p0;
      logic [ORBIT-1:0][P1_W-1:0]      p1;
   } ffwrm_m1_type;

   typedef struct packed {
      logic [ORBIT-1:0]                neg;
      logic [CNT_W-1:0]                cnt;
      logic [SSUM_W-1:0]               ssum;
      logic [WSUM_W-1:0]               wsum;
      logic [ORBIT-1:0][PROD_W-1:0]    prod;
   } ffwrm_m2_type;

   typedef struct packed {
      logic [CNT_W-1:0]                cnt;
      logic [SSUM_W-1:0]               ssum;
      logic [WSUM_W-1:0]               wsum;
      logic signed [ACC_W-1:0]         acc;
   } ffwrm_sum_type;

   typedef struct packed {
      logic                            neg;
      logic                            zero;
      logic [WSUM_W-1:0]               wsum;
      logic [SIG_W-1:0]                sigma;
      logic [WSUM_W-1:0]               rem;
      logic [AMP_W-1:0]                lo;
      logic [AMP_W-1:0]                q;
   } ffwrm_dstage_type;

endpackage

@@ sv/four_fold_weighted_reflection_merge_unit.sv @@
// ----------------------------------------------------------------------------
// four_fold_weighted_reflection_merge_unit
// Inverse-variance weighted merge of a four-fold symmetry orbit.
// ----------------------------------------------------------------------------
// Accepts one orbit (four amplitude/sigma pairs) per clock and returns one
// merged amplitude and sigma per orbit, in order. Throughput is one orbit
// per cycle while the response side does not stall. The pipeline runs through
// the 41-stage weight divider (one quotient bit per stage) followed by the
// 24-stage quotient divider for the weighted mean, plus the multiply, sum
// and register stages around them. A four-entry queue between the
// classifier and the arithmetic pipeline absorbs short response stalls.
module four_fold_weighted_reflection_merge_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // amp_a, amp_b, amp_c, amp_d, sigma_a, sigma_b, sigma_c, sigma_d
   input  logic [ffwrm_pkg::REQ_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // merged_amp, merged_sigma
   output logic [ffwrm_pkg::RSP_W-1:0]   rsp_tdata
);
   import ffwrm_pkg::*;

   logic           f_valid, f_ready, q_valid, q_ready;
   ffwrm_item_type f_item, q_item;
   logic [AMP_W-1:0] amp;
   logic [SIG_W-1:0] sigma;

   ffwrm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   ffwrm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   ffwrm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_amp   (amp),
      .out_sigma (sigma)
   );

   assign rsp_tdata = {sigma, amp};

endmodule

@@ sv/ffwrm_front.sv @@
// ----------------------------------------------------------------------------
// ffwrm_front
// Accepts an orbit, marks present entries, splits amplitudes into sign and
// magnitude, forms sigma^2 + 1, the sigma sum and the present count.
// ----------------------------------------------------------------------------
module ffwrm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [ffwrm_pkg::REQ_W-1:0]   in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output ffwrm_pkg::ffwrm_item_type     out_item
);
   import ffwrm_pkg::*;

   logic           valid_ff, valid_in;
   ffwrm_item_type item_ff, item_in;

   always_comb begin
      logic [AMP_W-1:0] a;
      logic [SIG_W-1:0] s;
      item_in = '0;
      for (int l = 0; l < ORBIT; l++) begin
         a = in_data[l*AMP_W +: AMP_W];
         s = in_data[ORBIT*AMP_W + l*SIG_W +: SIG_W];
         item_in.pres[l] = (a != '0);
         item_in.neg[l]  = a[AMP_W-1];
         item_in.mag[l]  = a[AMP_W-1] ? (~a + AMP_W'(1)) : a;
         item_in.den[l]  = DEN_W'(s) * DEN_W'(s) + DEN_W'(1);
         item_in.ssum    = item_in.ssum + SSUM_W'(s);
         item_in.cnt     = item_in.cnt + CNT_W'(item_in.pres[l]);
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign valid_in  = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ sv/ffwrm_queue.sv @@
// ----------------------------------------------------------------------------
// ffwrm_queue
// Short request queue between the classifier and the arithmetic pipeline.
// ----------------------------------------------------------------------------
`include "four_fold_weighted_reflection_merge_unit_assert.svh"

module ffwrm_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  ffwrm_pkg::ffwrm_item_type in_item,
   output logic                      out_valid,
   input  logic                      out_ready,
   output ffwrm_pkg::ffwrm_item_type out_item
);
   import ffwrm_pkg::*;

   ffwrm_item_type      mem [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign in_ready  = (count_ff != QCNT_W'(QDEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign wr_in     = push ? wr_ff + QPTR_W'(1) : wr_ff;
   assign rd_in     = pop ? rd_ff + QPTR_W'(1) : rd_ff;
   assign count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= in_item;
      end
   end

   `FFWRM_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= QCNT_W'(QDEPTH))
   `FFWRM_ASSERT_NEXT(a_count_up, push && !pop, count_ff == $past(count_ff) + QCNT_W'(1))
   `FFWRM_ASSERT_NEXT(a_count_down, pop && !push, count_ff == $past(count_ff) - QCNT_W'(1))
   `FFWRM_ASSERT_NOW(a_ptr_gap, 1'b1,
      (wr_ff - rd_ff) == count_ff[QPTR_W-1:0])

endmodule

@@ sv/ffwrm_back.sv @@
// ----------------------------------------------------------------------------
// ffwrm_back
// Arithmetic pipeline: per-entry weight by restoring division, weighted
// products and sums, sigma mean, then the final quotient one bit a stage.
// The whole pipeline holds when the output register is full and stalled.
// ----------------------------------------------------------------------------
module ffwrm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  ffwrm_pkg::ffwrm_item_type     in_item,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [ffwrm_pkg::AMP_W-1:0]   out_amp,
   output logic [ffwrm_pkg::SIG_W-1:0]   out_sigma
);
   import ffwrm_pkg::*;

   localparam int WST = W_W;     // weight quotient stages
   localparam int DST = AMP_W;   // final quotient stages

   logic adv;

   logic              wv_ff [WST], wv_in [WST];
   ffwrm_wstage_type  ws_ff [WST], ws_in [WST];
   logic              m1v_ff, m2v_ff, sv_ff, av_ff;
   ffwrm_m1_type      m1_ff, m1_in;
   ffwrm_m2_type      m2_ff, m2_in;
   ffwrm_sum_type     s_ff, s_in;
   ffwrm_dstage_type  a_in;
   logic              dv_ff [DST], dv_in [DST];
   ffwrm_dstage_type  ds_ff [DST], ds_in [DST];
   logic              ov_ff;
   logic [AMP_W-1:0]  oamp_ff, oamp_in;
   logic [SIG_W-1:0]  osig_ff;
   ffwrm_dstage_type  a_ff;

   assign adv      = !ov_ff || out_ready;
   assign in_ready = adv;

   // weight = 2^WSH / den, numerator has only its top bit set
   always_comb begin
      logic [DEN_W:0] r2;
      for (int k = 0; k < WST; k++) begin
         if (k == 0) begin
            ws_in[k].item = in_item;
            ws_in[k].rem  = '0;
            ws_in[k].q    = '0;
            wv_in[k]      = in_valid;
         end else begin
            ws_in[k] = ws_ff[k-1];
            wv_in[k] = wv_ff[k-1];
         end
         for (int l = 0; l < ORBIT; l++) begin
            r2 = {ws_in[k].rem[l], (k == 0)};
            if (r2 >= {1'b0, ws_in[k].item.den[l]}) begin
               ws_in[k].rem[l] = DEN_W'(r2 - {1'b0, ws_in[k].item.den[l]});
               ws_in[k].q[l]   = {ws_in[k].q[l][W_W-2:0], 1'b1};
            end else begin
               ws_in[k].rem[l] = r2[DEN_W-1:0];
               ws_in[k].q[l]   = {ws_in[k].q[l][W_W-2:0], 1'b0};
            end
         end
      end
   end

   // split multiply and weight sum
   always_comb begin
      logic [W_W-1:0] w;
      m1_in      = '0;
      m1_in.neg  = ws_ff[WST-1].item.neg;
      m1_in.cnt  = ws_ff[WST-1].item.cnt;
      m1_in.ssum = ws_ff[WST-1].item.ssum;
      for (int l = 0; l < ORBIT; l++) begin
         w = ws_ff[WST-1].item.pres[l] ? ws_ff[WST-1].q[l] : '0;
         m1_in.wsum  = m1_in.wsum + WSUM_W'(w);
         m1_in.p0[l] = P0_W'(ws_ff[WST-1].item.mag[l]) * P0_W'(w[AMP_W-1:0]);
         m1_in.p1[l] = P1_W'(ws_ff[WST-1].item.mag[l]) * P1_W'(w[W_W-1:AMP_W]);
      end
   end

   always_comb begin
      m2_in.neg  = m1_ff.neg;
      m2_in.cnt  = m1_ff.cnt;
      m2_in.ssum = m1_ff.ssum;
      m2_in.wsum = m1_ff.wsum;
      for (int l = 0; l < ORBIT; l++) begin
         m2_in.prod[l] = PROD_W'(m1_ff.p0[l]) + {m1_ff.p1[l], {AMP_W{1'b0}}};
      end
   end

   always_comb begin
      logic signed [ACC_W-1:0] t;
      s_in.cnt  = m2_ff.cnt;
      s_in.ssum = m2_ff.ssum;
      s_in.wsum = m2_ff.wsum;
      s_in.acc  = '0;
      for (int l = 0; l < ORBIT; l++) begin
         t = signed'({2'b00, m2_ff.prod[l]});
         s_in.acc = m2_ff.neg[l] ? s_in.acc - t : s_in.acc + t;
      end
   end

   // sign/magnitude of the weighted sum, sigma mean with saturation
   always_comb begin
      logic [MAG_W-1:0]              mag;
      logic [SSUM_W-1:0]             sq;
      logic [SSUM_W+RECIP3_SH-1:0]   p3;
      p3   = (SSUM_W + RECIP3_SH)'(s_ff.ssum) * (SSUM_W + RECIP3_SH)'(RECIP3);
      mag  = s_ff.acc[ACC_W-1] ? MAG_W'(-s_ff.acc) : MAG_W'(s_ff.acc);
      unique case (s_ff.cnt)
         CNT_W'(2): sq = s_ff.ssum >> 1;
         CNT_W'(3): sq = p3[RECIP3_SH +: SSUM_W];
         CNT_W'(4): sq = s_ff.ssum >> 2;
         default:   sq = s_ff.ssum;
      endcase
      a_in.neg   = s_ff.acc[ACC_W-1];
      a_in.zero  = (s_ff.wsum == '0);
      a_in.wsum  = s_ff.wsum;
      a_in.sigma = (sq > SSUM_W'({SIG_W{1'b1}})) ? {SIG_W{1'b1}} : sq[SIG_W-1:0];
      // quotient stays below 2^AMP_W, so the top part starts below wsum
      a_in.rem   = WSUM_W'(mag[MAG_W-1:AMP_W]);
      a_in.lo    = mag[AMP_W-1:0];
      a_in.q     = '0;
   end

   always_comb begin
      logic [WSUM_W:0] r2;
      for (int k = 0; k < DST; k++) begin
         if (k == 0) begin
            ds_in[k] = a_ff;
            dv_in[k] = av_ff;
         end else begin
            ds_in[k] = ds_ff[k-1];
            dv_in[k] = dv_ff[k-1];
         end
         r2 = {ds_in[k].rem, ds_in[k].lo[AMP_W-1]};
         ds_in[k].lo = {ds_in[k].lo[AMP_W-2:0], 1'b0};
         if (r2 >= {1'b0, ds_in[k].wsum}) begin
            ds_in[k].rem = WSUM_W'(r2 - {1'b0, ds_in[k].wsum});
            ds_in[k].q   = {ds_in[k].q[AMP_W-2:0], 1'b1};
         end else begin
            ds_in[k].rem = r2[WSUM_W-1:0];
            ds_in[k].q   = {ds_in[k].q[AMP_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (ds_ff[DST-1].zero) begin
         oamp_in = '0;
      end else if (ds_ff[DST-1].neg) begin
         oamp_in = -ds_ff[DST-1].q;
      end else begin
         oamp_in = ds_ff[DST-1].q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WST; k++) wv_ff[k] <= 1'b0;
         for (int k = 0; k < DST; k++) dv_ff[k] <= 1'b0;
         m1v_ff <= 1'b0;
         m2v_ff <= 1'b0;
         sv_ff  <= 1'b0;
         av_ff  <= 1'b0;
         ov_ff  <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k < WST; k++) wv_ff[k] <= wv_in[k];
         for (int k = 0; k < DST; k++) dv_ff[k] <= dv_in[k];
         m1v_ff <= wv_ff[WST-1];
         m2v_ff <= m1v_ff;
         sv_ff  <= m2v_ff;
         av_ff  <= sv_ff;
         ov_ff  <= dv_ff[DST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < WST; k++) ws_ff[k] <= ws_in[k];
         for (int k = 0; k < DST; k++) ds_ff[k] <= ds_in[k];
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         s_ff    <= s_in;
         a_ff    <= a_in;
         oamp_ff <= oamp_in;
         osig_ff <= ds_ff[DST-1].sigma;
      end
   end

   assign out_valid = ov_ff;
   assign out_amp   = oamp_ff;
   assign out_sigma = osig_ff;

endmodule
